/* hdl/assert_macros.svh */
// Assertion macros used by the checker file oada_checker.sv.
// Include with the bare file name; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/oada_pkg.sv */
// Types and constants of the obstacle-avoidance drive arbiter.
// No dependencies; used by the top level, the checker and the bench.
`default_nettype none

package oada_pkg;

   typedef logic [1:0] phase_type;
   localparam phase_type PH_CLEAR  = 2'd0;
   localparam phase_type PH_HIT    = 2'd1;
   localparam phase_type PH_AVOID1 = 2'd2;
   localparam phase_type PH_AVOID2 = 2'd3;

   typedef enum logic [1:0] {
      ACT_NOTHING,
      ACT_LEFT,
      ACT_BACK
   } action_type;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_MAN_RELOAD   = 2'd0;
   localparam csr_index_type CSR_AUTO_RELOAD  = 2'd1;
   localparam csr_index_type CSR_CRUISE_SPEED = 2'd2;
   localparam csr_index_type CSR_TURN_SPEED   = 2'd3;

   localparam int CSR_DATA_WIDTH = 11;

   localparam logic [7:0]  MAN_RELOAD_RESET   = 8'd16;
   localparam logic [7:0]  AUTO_RELOAD_RESET  = 8'd2;
   localparam logic [8:0]  CRUISE_SPEED_RESET = 9'd200;
   localparam logic [10:0] TURN_SPEED_RESET   = 11'd1000;

   localparam logic [15:0] RADIUS_STRAIGHT = 16'h8000;
   localparam logic [15:0] RADIUS_LEFT     = 16'hFFFF;
   localparam logic [15:0] RADIUS_NONE     = 16'h0000;

endpackage

`default_nettype wire

/* hdl/oada_chan_if.sv */
// Valid/ready channels of the drive arbiter: sensor item in, drive item out.
// Depends on nothing but the language.
`default_nettype none

interface oada_req_if;
   logic               valid;
   logic               ready;
   logic               ir_hit;
   logic               bumper_hit;
   logic               manual_present;
   logic signed [9:0]  manual_velocity;
   logic signed [15:0] manual_radius;

   modport source (output valid, ir_hit, bumper_hit, manual_present, manual_velocity,
                   manual_radius, input ready);
   modport sink   (input valid, ir_hit, bumper_hit, manual_present, manual_velocity,
                   manual_radius, output ready);
endinterface

interface oada_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] drive_velocity;
   logic signed [15:0] drive_radius;
   logic               auto_active;

   modport source (output valid, drive_velocity, drive_radius, auto_active, input ready);
   modport sink   (input valid, drive_velocity, drive_radius, auto_active, output ready);
endinterface

`default_nettype wire

/* hdl/obstacle_avoid_drive_arbiter.sv */
// Obstacle-avoidance drive arbiter. Each accepted sensor item is one control tick: it
// lands in an input register, the avoidance phase, mode and backoff counter update as it
// leaves that register, and its drive item (if any) waits in the result register. One
// item per clock is sustained while the result side keeps ready high; an item passes
// through the input register and then the result register. Ticks in auto mode that carry a
// manual command update the state but give no result. The csr port is to be written only
// while the block is idle; the block itself does not enforce it. Indexes follow the
// register list (manual reload, auto reload, cruise speed, turn speed).
// Depends on oada_pkg and the channel interfaces in oada_chan_if.
`default_nettype none

module obstacle_avoid_drive_arbiter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   oada_req_if.sink                                 req_chan,
   oada_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_write_enable,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [oada_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);

   logic [7:0]  man_reload_ff;
   logic [7:0]  auto_reload_ff;
   logic [8:0]  cruise_speed_ff;
   logic [10:0] turn_speed_ff;

   oada_pkg::phase_type phase_ff, phase_in;
   logic                auto_mode_ff, auto_mode_in;
   logic [7:0]          count_ff, count_in;

   logic               s1_valid_ff;
   logic               s1_ir_ff, s1_bump_ff, s1_man_ff;
   logic [9:0]         s1_mvel_ff;
   logic [15:0]        s1_mrad_ff;

   logic               s2_valid_ff, s2_valid_in;
   logic [11:0]        s2_vel_ff;
   logic [15:0]        s2_rad_ff;
   logic               s2_auto_ff;

   oada_pkg::action_type act;
   logic                 emit;
   logic [11:0]          vel;
   logic [15:0]          rad;
   logic [11:0]          act_vel;
   logic [15:0]          act_rad;
   logic [7:0]           count_dec;
   logic                 s2_free, s1_adv, req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         man_reload_ff   <= oada_pkg::MAN_RELOAD_RESET;
         auto_reload_ff  <= oada_pkg::AUTO_RELOAD_RESET;
         cruise_speed_ff <= oada_pkg::CRUISE_SPEED_RESET;
         turn_speed_ff   <= oada_pkg::TURN_SPEED_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            oada_pkg::CSR_MAN_RELOAD:   man_reload_ff   <= csr_write_data[7:0];
            oada_pkg::CSR_AUTO_RELOAD:  auto_reload_ff  <= csr_write_data[7:0];
            oada_pkg::CSR_CRUISE_SPEED: cruise_speed_ff <= csr_write_data[8:0];
            oada_pkg::CSR_TURN_SPEED:   turn_speed_ff   <= csr_write_data[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      act      = oada_pkg::ACT_NOTHING;
      unique case (phase_ff) inside
         oada_pkg::PH_CLEAR: begin
            if (s1_ir_ff || s1_bump_ff) begin
               phase_in = oada_pkg::PH_HIT;
               act      = oada_pkg::ACT_BACK;
            end
         end
         oada_pkg::PH_HIT: begin
            if (!s1_bump_ff) begin
               phase_in = oada_pkg::PH_AVOID1;
               act      = oada_pkg::ACT_LEFT;
            end else begin
               act = oada_pkg::ACT_BACK;
            end
         end
         oada_pkg::PH_AVOID1, oada_pkg::PH_AVOID2: begin
            if (s1_ir_ff) begin
               act = oada_pkg::ACT_LEFT;
            end else if (s1_bump_ff) begin
               phase_in = oada_pkg::PH_HIT;
               act      = oada_pkg::ACT_BACK;
            end else if (phase_ff == oada_pkg::PH_AVOID1) begin
               phase_in = oada_pkg::PH_AVOID2;
               act      = oada_pkg::ACT_LEFT;
            end else begin
               phase_in = oada_pkg::PH_CLEAR;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      case (act)
         oada_pkg::ACT_LEFT: begin
            act_vel = {1'b0, turn_speed_ff};
            act_rad = oada_pkg::RADIUS_LEFT;
         end
         oada_pkg::ACT_BACK: begin
            act_vel = 12'd0 - {3'b000, cruise_speed_ff};
            act_rad = oada_pkg::RADIUS_STRAIGHT;
         end
         default: begin
            act_vel = {3'b000, cruise_speed_ff};
            act_rad = oada_pkg::RADIUS_STRAIGHT;
         end
      endcase
   end

   assign count_dec = count_ff - 8'd1;

   always_comb begin
      auto_mode_in = auto_mode_ff;
      count_in     = count_ff;
      emit         = 1'b1;
      vel          = 12'd0;
      rad          = oada_pkg::RADIUS_NONE;
      if (!auto_mode_ff) begin
         if (act != oada_pkg::ACT_NOTHING) begin
            auto_mode_in = 1'b1;
            count_in     = auto_reload_ff;
            vel          = act_vel;
            rad          = act_rad;
         end else if (s1_man_ff) begin
            count_in = man_reload_ff;
            vel      = {{2{s1_mvel_ff[9]}}, s1_mvel_ff};
            rad      = s1_mrad_ff;
         end else if (count_dec == 8'd0) begin
            auto_mode_in = 1'b1;
            count_in     = auto_reload_ff;
         end else begin
            count_in = count_dec;
         end
      end else if (s1_man_ff) begin
         emit = 1'b0;
         if (count_dec == 8'd0) begin
            auto_mode_in = 1'b0;
            count_in     = man_reload_ff;
         end else begin
            count_in = count_dec;
         end
      end else begin
         count_in = auto_reload_ff;
         vel      = act_vel;
         rad      = act_rad;
      end
   end

   assign s2_free  = !s2_valid_ff || rsp_chan.ready;
   assign s1_adv   = s1_valid_ff && (s2_free || !emit);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || s1_adv;

   always_comb begin
      if (s1_adv && emit) begin
         s2_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= oada_pkg::PH_CLEAR;
         auto_mode_ff <= 1'b0;
         count_ff     <= oada_pkg::MAN_RELOAD_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         if (s1_adv) begin
            phase_ff     <= phase_in;
            auto_mode_ff <= auto_mode_in;
            count_ff     <= count_in;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ir_ff   <= req_chan.ir_hit;
         s1_bump_ff <= req_chan.bumper_hit;
         s1_man_ff  <= req_chan.manual_present;
         s1_mvel_ff <= req_chan.manual_velocity;
         s1_mrad_ff <= req_chan.manual_radius;
      end
      if (s1_adv && emit) begin
         s2_vel_ff  <= vel;
         s2_rad_ff  <= rad;
         s2_auto_ff <= auto_mode_in;
      end
   end

   assign rsp_chan.valid          = s2_valid_ff;
   assign rsp_chan.drive_velocity = s2_vel_ff;
   assign rsp_chan.drive_radius   = s2_rad_ff;
   assign rsp_chan.auto_active    = s2_auto_ff;

endmodule

`default_nettype wire

/* hdl/oada_checker.sv */
// Port-level checks for the drive arbiter, bound to the top level.
// Depends on oada_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module oada_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [11:0] rsp_drive_velocity,
   input wire logic [15:0] rsp_drive_radius,
   input wire logic        rsp_auto_active
);

   logic        stalled;
   logic        radius_auto_ok;
   logic [28:0] rsp_payload;

   assign stalled        = rsp_valid && !rsp_ready;
   assign rsp_payload    = {rsp_drive_velocity, rsp_drive_radius, rsp_auto_active};
   assign radius_auto_ok = (rsp_drive_radius == oada_pkg::RADIUS_STRAIGHT) ||
                           (rsp_drive_radius == oada_pkg::RADIUS_LEFT) ||
                           (rsp_drive_radius == oada_pkg::RADIUS_NONE);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, stalled, $stable(rsp_payload))
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   `ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `ASSERT_IMPL(a_auto_radius, clock, reset, rsp_valid && rsp_auto_active, radius_auto_ok)

endmodule

bind obstacle_avoid_drive_arbiter oada_checker u_oada_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_drive_velocity (rsp_chan.drive_velocity),
   .rsp_drive_radius   (rsp_chan.drive_radius),
   .rsp_auto_active    (rsp_chan.auto_active)
);

`default_nettype wire

/* tb/sv/tb_obstacle_avoid_drive_arbiter.sv */
// Self-checking bench for the obstacle-avoidance drive arbiter: a tick predictor with
// its own phase, mode and backoff state checks every drive item in order.
// Needs oada_pkg, the channel interfaces and the obstacle_avoid_drive_arbiter top level.
module tb_obstacle_avoid_drive_arbiter;

   localparam int HALF_PERIOD   = 5;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PRINT_LIMIT   = 30;
   localparam int HOLD_STRETCH  = 150;

   typedef struct packed {
      logic [11:0] velocity;
      logic [15:0] radius;
      logic        auto_active;
   } drive_item_type;

   typedef logic [oada_pkg::CSR_DATA_WIDTH-1:0] csr_data_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_write_enable;
   logic [1:0]   csr_index;
   csr_data_type csr_write_data;

   oada_req_if req_chan ();
   oada_rsp_if rsp_chan ();

   obstacle_avoid_drive_arbiter dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [7:0]  cfg_man_reload;
   logic [7:0]  cfg_auto_reload;
   logic [8:0]  cfg_cruise_speed;
   logic [10:0] cfg_turn_speed;

   oada_pkg::phase_type track_phase;
   logic                track_auto;
   logic [7:0]          track_count;

   drive_item_type expected_drive[$];

   int error_count      = 0;
   int items_accepted   = 0;
   int drives_checked   = 0;
   int settings_applied = 0;
   int mode_changes     = 0;
   int silent_ticks     = 0;
   int cycle_count      = 0;
   int hold_cycles      = 0;
   bit gap_off          = 1'b0;
   bit stall_off        = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d drive items outstanding", cycle_count,
                  expected_drive.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic drive_item_type action_drive(input oada_pkg::action_type act);
      drive_item_type d;
      d.auto_active = 1'b1;
      case (act)
         oada_pkg::ACT_LEFT: begin
            d.velocity = {1'b0, cfg_turn_speed};
            d.radius   = oada_pkg::RADIUS_LEFT;
         end
         oada_pkg::ACT_BACK: begin
            d.velocity = 12'd0 - {3'b000, cfg_cruise_speed};
            d.radius   = oada_pkg::RADIUS_STRAIGHT;
         end
         default: begin
            d.velocity = {3'b000, cfg_cruise_speed};
            d.radius   = oada_pkg::RADIUS_STRAIGHT;
         end
      endcase
      return d;
   endfunction

   task automatic reset_model();
      cfg_man_reload   = oada_pkg::MAN_RELOAD_RESET;
      cfg_auto_reload  = oada_pkg::AUTO_RELOAD_RESET;
      cfg_cruise_speed = oada_pkg::CRUISE_SPEED_RESET;
      cfg_turn_speed   = oada_pkg::TURN_SPEED_RESET;
      track_phase      = oada_pkg::PH_CLEAR;
      track_auto       = 1'b0;
      track_count      = oada_pkg::MAN_RELOAD_RESET;
   endtask

   task automatic predict_drive(input logic ir, input logic bump, input logic man,
                                input logic [9:0] mvel, input logic [15:0] mrad);
      oada_pkg::action_type act;
      drive_item_type       d;
      logic                 emit;
      logic                 was_auto;
      emit     = 1'b1;
      was_auto = track_auto;
      act      = oada_pkg::ACT_NOTHING;
      case (track_phase)
         oada_pkg::PH_CLEAR: begin
            if (ir || bump) begin
               track_phase = oada_pkg::PH_HIT;
               act         = oada_pkg::ACT_BACK;
            end
         end
         oada_pkg::PH_HIT: begin
            if (!bump) begin
               track_phase = oada_pkg::PH_AVOID1;
               act         = oada_pkg::ACT_LEFT;
            end else begin
               act = oada_pkg::ACT_BACK;
            end
         end
         oada_pkg::PH_AVOID1: begin
            if (ir) begin
               act = oada_pkg::ACT_LEFT;
            end else if (bump) begin
               track_phase = oada_pkg::PH_HIT;
               act         = oada_pkg::ACT_BACK;
            end else begin
               track_phase = oada_pkg::PH_AVOID2;
               act         = oada_pkg::ACT_LEFT;
            end
         end
         default: begin
            if (ir) begin
               act = oada_pkg::ACT_LEFT;
            end else if (bump) begin
               track_phase = oada_pkg::PH_HIT;
               act         = oada_pkg::ACT_BACK;
            end else begin
               track_phase = oada_pkg::PH_CLEAR;
            end
         end
      endcase

      if (!track_auto) begin
         if (act != oada_pkg::ACT_NOTHING) begin
            track_auto  = 1'b1;
            track_count = cfg_auto_reload;
            d           = action_drive(act);
         end else if (man) begin
            track_count = cfg_man_reload;
            d.velocity  = {{2{mvel[9]}}, mvel};
            d.radius    = mrad;
         end else begin
            track_count = track_count - 8'd1;
            if (track_count == 8'd0) begin
               track_auto  = 1'b1;
               track_count = cfg_auto_reload;
            end
            d.velocity = 12'd0;
            d.radius   = oada_pkg::RADIUS_NONE;
         end
      end else if (man) begin
         emit        = 1'b0;
         track_count = track_count - 8'd1;
         if (track_count == 8'd0) begin
            track_auto  = 1'b0;
            track_count = cfg_man_reload;
         end
      end else begin
         track_count = cfg_auto_reload;
         d           = action_drive(act);
      end

      if (track_auto != was_auto)
         mode_changes++;
      if (emit) begin
         d.auto_active = track_auto;
         expected_drive.push_back(d);
      end else begin
         silent_ticks++;
      end
   endtask

   // Drive results: compare each accepted item with the oldest expectation.
   always @(posedge clock) begin : check_drive
      drive_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_drive.size() == 0) begin
            report_mismatch($sformatf("unexpected drive item vel %0d rad %0d auto %0b",
                                      rsp_chan.drive_velocity, rsp_chan.drive_radius,
                                      rsp_chan.auto_active));
         end else begin
            want = expected_drive.pop_front();
            drives_checked++;
            if (rsp_chan.drive_velocity !== want.velocity)
               report_mismatch($sformatf("drive_velocity %0d, expected %0d",
                                         rsp_chan.drive_velocity, $signed(want.velocity)));
            if (rsp_chan.drive_radius !== want.radius)
               report_mismatch($sformatf("drive_radius %0d, expected %0d",
                                         rsp_chan.drive_radius, $signed(want.radius)));
            if (rsp_chan.auto_active !== want.auto_active)
               report_mismatch($sformatf("auto_active %0b, expected %0b",
                                         rsp_chan.auto_active, want.auto_active));
         end
      end
   end

   // Result side: random stalls per item, plus a long hold when asked.
   initial begin : drive_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_chan.ready = 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
         end
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready)
            stall_left = stall_off ? 0 : $urandom_range(0, 11);
      end
   end

   task automatic send_tick(input logic ir, input logic bump, input logic man,
                            input logic [9:0] mvel, input logic [15:0] mrad);
      int gap;
      gap = gap_off ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.ir_hit          = ir;
      req_chan.bumper_hit      = bump;
      req_chan.manual_present  = man;
      req_chan.manual_velocity = mvel;
      req_chan.manual_radius   = mrad;
      req_chan.valid           = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_drive(ir, bump, man, mvel, mrad);
      items_accepted++;
   endtask

   task automatic send_random_tick(input bit with_manual);
      send_tick($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0, with_manual,
                10'($urandom), 16'($urandom));
   endtask

   // Drop valid, wait for every drive item, then let in-flight silent ticks retire.
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_drive.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input oada_pkg::csr_index_type idx, input csr_data_type value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      case (idx)
         oada_pkg::CSR_MAN_RELOAD:   cfg_man_reload   = value[7:0];
         oada_pkg::CSR_AUTO_RELOAD:  cfg_auto_reload  = value[7:0];
         oada_pkg::CSR_CRUISE_SPEED: cfg_cruise_speed = value[8:0];
         default:                    cfg_turn_speed   = value[10:0];
      endcase
   endtask

   task automatic apply_setting(input csr_data_type manual_reload,
                                input csr_data_type auto_reload,
                                input csr_data_type cruise,
                                input csr_data_type turn);
      wait_idle();
      csr_write(oada_pkg::CSR_MAN_RELOAD, manual_reload);
      csr_write(oada_pkg::CSR_AUTO_RELOAD, auto_reload);
      csr_write(oada_pkg::CSR_CRUISE_SPEED, cruise);
      csr_write(oada_pkg::CSR_TURN_SPEED, turn);
      @(negedge clock);
      csr_write_enable = 1'b0;
      settings_applied++;
   endtask

   // Runs of idle, manual, obstacle and mixed ticks so that every phase and mode is visited.
   task automatic run_random(input int item_total);
      int sent;
      int run_len;
      int style;
      int k;
      sent = 0;
      while (sent < item_total) begin
         style     = $urandom_range(0, 9);
         run_len   = $urandom_range(1, 16);
         gap_off   = ($urandom_range(0, 7) == 0);
         stall_off = gap_off;
         for (k = 0; k < run_len && sent < item_total; k++) begin
            case (style) inside
               0, 1:    send_tick(1'b0, 1'b0, 1'b0, 10'($urandom), 16'($urandom));
               2, 3, 4: send_tick(1'b0, 1'b0, 1'b1, 10'($urandom), 16'($urandom));
               5, 6:    send_random_tick(1'b0);
               7:       send_random_tick(1'b1);
               default: send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 10'($urandom),
                                  16'($urandom));
            endcase
            sent++;
         end
      end
      gap_off   = 1'b0;
      stall_off = 1'b0;
   endtask

   task automatic test_directed_ticks();
      send_tick(1'b0, 1'b0, 1'b1, 10'h1FF, 16'h8000);
      send_tick(1'b0, 1'b0, 1'b1, 10'h200, 16'h7FFF);
      send_tick(1'b0, 1'b0, 1'b1, 10'sd500, 16'h0000);
      send_tick(1'b0, 1'b0, 1'b1, -10'sd500, 16'hFFFF);
      send_tick(1'b0, 1'b0, 1'b0, 10'h155, 16'hAAAA);
      send_tick(1'b1, 1'b0, 1'b0, 10'h2AA, 16'h5555);
      send_tick(1'b0, 1'b1, 1'b1, 10'h000, 16'h0001);
      send_tick(1'b0, 1'b0, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b1, 1'b0, 1'b1, 10'h3FF, 16'hFFFF);
      send_tick(1'b0, 1'b0, 1'b1, 10'h001, 16'h0100);
      send_tick(1'b0, 1'b1, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b0, 1'b0, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b0, 1'b0, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b0, 1'b0, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b1, 1'b1, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b1, 1'b1, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b1, 1'b0, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b0, 1'b1, 1'b0, 10'h000, 16'h0000);
   endtask

   // Upper data bits are junk and must be masked off; auto reload lands at zero.
   task automatic test_counter_wrap();
      apply_setting(11'h702, 11'h700, 11'h7F4, 11'h7FF);
      send_tick(1'b0, 1'b0, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b0, 1'b0, 1'b1, 10'h0AA, 16'h1234);
      send_tick(1'b0, 1'b0, 1'b0, 10'h000, 16'h0000);
      send_tick(1'b0, 1'b1, 1'b0, 10'h000, 16'h0000);
   endtask

   task automatic test_setting_sweep();
      int k;
      apply_setting(11'd1, 11'd1, 11'd0, 11'd0);
      run_random(250);
      apply_setting(11'd255, 11'd255, 11'd500, 11'd2047);
      run_random(250);
      apply_setting(11'd0, 11'd0, 11'd1, 11'd1);
      run_random(250);
      for (k = 0; k < 3; k++) begin
         apply_setting(csr_data_type'($urandom_range(1, 12)),
                       csr_data_type'($urandom_range(1, 12)),
                       csr_data_type'($urandom_range(0, 500)),
                       csr_data_type'($urandom_range(0, 2047)));
         run_random(250);
      end
      apply_setting(csr_data_type'(oada_pkg::MAN_RELOAD_RESET),
                    csr_data_type'(oada_pkg::AUTO_RELOAD_RESET),
                    csr_data_type'(oada_pkg::CRUISE_SPEED_RESET),
                    csr_data_type'(oada_pkg::TURN_SPEED_RESET));
      run_random(250);
   endtask

   // Hold the result side while the sender keeps offering ticks that all give results.
   task automatic test_backpressure();
      int k;
      wait_idle();
      hold_cycles = HOLD_STRETCH;
      gap_off     = 1'b1;
      for (k = 0; k < 60; k++)
         send_random_tick(1'b0);
      gap_off = 1'b0;
   endtask

   task automatic test_pause_drain();
      int round;
      int k;
      for (round = 0; round < 3; round++) begin
         for (k = 0; k < 12; k++)
            send_random_tick(1'($urandom_range(0, 1)));
         wait_idle();
      end
   endtask

   initial begin
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.ir_hit          = 1'b0;
      req_chan.bumper_hit      = 1'b0;
      req_chan.manual_present  = 1'b0;
      req_chan.manual_velocity = '0;
      req_chan.manual_radius   = '0;
      rsp_chan.ready           = 1'b0;
      csr_write_enable         = 1'b0;
      csr_index                = oada_pkg::CSR_MAN_RELOAD;
      csr_write_data           = '0;
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ticks();
      test_counter_wrap();
      test_setting_sweep();
      test_backpressure();
      test_pause_drain();
      wait_idle();

      $display("covered %0d ticks under %0d register settings, %0d drive items checked",
               items_accepted, settings_applied, drives_checked);
      $display("%0d mode changes, %0d auto ticks absorbed a manual command, %0d mismatches",
               mode_changes, silent_ticks, error_count);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/oada_pkg.sv
hdl/oada_chan_if.sv
hdl/obstacle_avoid_drive_arbiter.sv
hdl/oada_checker.sv
tb/sv/tb_obstacle_avoid_drive_arbiter.sv
